// File: sv/http2_settings_payload_parser_defines.svh
// ---------------------------------------------------------------------------
// HTTP/2 SETTINGS payload parser: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ---------------------------------------------------------------------------
`ifndef HTTP2_SETTINGS_PAYLOAD_PARSER_DEFINES_SVH
`define HTTP2_SETTINGS_PAYLOAD_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hsp_pkg.sv
// ---------------------------------------------------------------------------
// HTTP/2 SETTINGS payload parser package
// Types, codes and constants shared by the parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [15:0] ID_HEADER_TABLE = 16'h0001;
  localparam logic [15:0] ID_PUSH         = 16'h0002;
  localparam logic [15:0] ID_STREAMS      = 16'h0003;
  localparam logic [15:0] ID_WINDOW       = 16'h0004;
  localparam logic [15:0] ID_FRAME_SIZE   = 16'h0005;
  localparam logic [15:0] ID_HEADER_LIST  = 16'h0006;

  localparam logic [30:0] DEF_HEADER_TABLE = 31'd4096;
  localparam logic [30:0] DEF_STREAMS      = 31'd100;
  localparam logic [30:0] DEF_WINDOW       = 31'd65535;
  localparam logic [23:0] DEF_FRAME_SIZE   = 24'd16384;

  // Index of the last byte of a six-byte entry.
  localparam logic [2:0] LAST_POS = 3'd5;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 152;
  localparam int unsigned OUT_USER_W = 1;

  // Decoded command for the item being processed.
  typedef struct packed {
    logic byte_en;
    logic end_en;
    logic clear_en;
  } cmd_t;

  // Entry assembler status toward the settings view.
  typedef struct packed {
    logic        complete;
    logic        partial;
    logic [15:0] id;
    logic [31:0] value;
  } entry_t;

  // Stored settings; a zero size or limit means unset (or unlimited for the header list).
  typedef struct packed {
    logic        push;
    logic [30:0] header_table;
    logic [30:0] streams;
    logic [30:0] window;
    logic [23:0] frame_size;
    logic [30:0] header_list;
  } view_t;

  localparam view_t VIEW_RESET = '{push: 1'b1, default: '0};

  // Effective values handed to the output register.
  typedef struct packed {
    logic        status;
    logic        push_enabled;
    logic [30:0] header_table_bytes;
    logic [30:0] concurrent_stream_limit;
    logic [30:0] initial_window_bytes;
    logic [23:0] frame_size_limit;
    logic [30:0] header_list_limit;
  } result_t;

endpackage

`default_nettype wire

// File: sv/hsp_entry_asm.sv
// ---------------------------------------------------------------------------
// HTTP/2 SETTINGS entry assembler
// Counts payload bytes modulo six and gathers the id and value of an entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsp_entry_asm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hsp_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    data_byte_i,
  output hsp_pkg::entry_t    entry_o
);

  logic [2:0]  pos_q, pos_d;
  logic [39:0] bytes_q, bytes_d;

  always_comb begin
    pos_d             = pos_q;
    bytes_d           = bytes_q;
    entry_o.complete  = 1'b0;
    entry_o.partial   = (pos_q != 3'd0);
    entry_o.id        = bytes_q[39:24];
    entry_o.value     = {bytes_q[23:0], data_byte_i};
    if (cmd_i.clear_en || cmd_i.end_en) begin
      pos_d   = '0;
      bytes_d = '0;
    end else if (cmd_i.byte_en) begin
      if (pos_q >= hsp_pkg::LAST_POS) begin
        // The sixth byte closes the entry; the value uses it directly.
        entry_o.complete = 1'b1;
        pos_d            = '0;
        bytes_d          = '0;
      end else begin
        pos_d   = pos_q + 3'd1;
        bytes_d = {bytes_q[31:0], data_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bytes_q <= '0;
    end else begin
      pos_q   <= pos_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/hsp_view.sv
// ---------------------------------------------------------------------------
// HTTP/2 SETTINGS peer view
// Holds the shadow and committed settings and forms the effective result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsp_view (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hsp_pkg::cmd_t   cmd_i,
  input  wire hsp_pkg::entry_t entry_i,
  output hsp_pkg::result_t     result_o
);

  hsp_pkg::view_t shadow_q, shadow_d;
  hsp_pkg::view_t committed_q, committed_d;
  hsp_pkg::view_t eff;
  logic           nonneg;
  logic           positive;
  logic           frame_ok;

  assign nonneg   = !entry_i.value[31];
  assign positive = nonneg && (entry_i.value != 32'd0);
  assign frame_ok = (entry_i.value[31:24] == 8'd0) &&
                    (entry_i.value[23:0] >= hsp_pkg::DEF_FRAME_SIZE);

  always_comb begin
    shadow_d    = shadow_q;
    committed_d = committed_q;
    if (cmd_i.clear_en) begin
      shadow_d    = hsp_pkg::VIEW_RESET;
      committed_d = hsp_pkg::VIEW_RESET;
    end else if (cmd_i.end_en) begin
      // A torn entry discards the shadow changes; otherwise they take effect.
      if (entry_i.partial) begin
        shadow_d = committed_q;
      end else begin
        committed_d = shadow_q;
      end
    end else if (entry_i.complete) begin
      unique case (entry_i.id)
        hsp_pkg::ID_HEADER_TABLE: begin
          if (positive) shadow_d.header_table = entry_i.value[30:0];
        end
        hsp_pkg::ID_PUSH: begin
          shadow_d.push = (entry_i.value != 32'd0);
        end
        hsp_pkg::ID_STREAMS: begin
          if (positive) shadow_d.streams = entry_i.value[30:0];
        end
        hsp_pkg::ID_WINDOW: begin
          if (nonneg) shadow_d.window = entry_i.value[30:0];
        end
        hsp_pkg::ID_FRAME_SIZE: begin
          if (frame_ok) shadow_d.frame_size = entry_i.value[23:0];
        end
        hsp_pkg::ID_HEADER_LIST: begin
          if (nonneg) shadow_d.header_list = entry_i.value[30:0];
        end
        default: begin
          // Unknown ids are ignored.
        end
      endcase
    end
  end

  // The view that will be committed after an end of payload.
  assign eff = entry_i.partial ? committed_q : shadow_q;

  always_comb begin
    result_o.status                  = entry_i.partial;
    result_o.push_enabled            = eff.push;
    result_o.header_table_bytes      = (eff.header_table == '0) ?
                                       hsp_pkg::DEF_HEADER_TABLE : eff.header_table;
    result_o.concurrent_stream_limit = (eff.streams == '0) ?
                                       hsp_pkg::DEF_STREAMS : eff.streams;
    result_o.initial_window_bytes    = (eff.window == '0) ?
                                       hsp_pkg::DEF_WINDOW : eff.window;
    result_o.frame_size_limit        = (eff.frame_size == '0) ?
                                       hsp_pkg::DEF_FRAME_SIZE : eff.frame_size;
    result_o.header_list_limit       = eff.header_list;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q    <= hsp_pkg::VIEW_RESET;
      committed_q <= hsp_pkg::VIEW_RESET;
    end else begin
      shadow_q    <= shadow_d;
      committed_q <= committed_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/http2_settings_payload_parser.sv
// ---------------------------------------------------------------------------
// HTTP/2 SETTINGS payload parser
// Parses a SETTINGS payload byte stream into the effective peer settings.
// ---------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel. The tuser field is the operation: a
// payload byte (carried in tdata), end of payload, or a clear of the peer
// view. Every six payload bytes form one entry, which updates a shadow view
// when its value is legal for its id. Only end of payload produces an item on
// the m_axis channel: tuser is the status (1 when the byte count was not a
// multiple of six, in which case the committed view is kept) and tdata carries
// the effective settings with protocol defaults filled in.
// Timing: an accepted item is registered, then processed; an end of payload
// loads its result into the output register, which drives m_axis_tvalid_o.
// One item per cycle is sustained unless an end of payload waits; the rate is
// set by the single input register feeding the entry assembler and view
// update. Reset clears the byte count, the partial entry and both views to
// the protocol defaults. When the receiver holds m_axis_tready_i low, payload
// bytes and clears keep flowing; an end of payload waits in the input register
// until the pending result is taken, and s_axis_tready_o drops meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http2_settings_payload_parser_defines.svh"

module http2_settings_payload_parser (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // [7:0] data_byte
  input  wire logic [hsp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [1:0] op
  input  wire logic [hsp_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [0] push_enabled, [31:1] header_table_bytes, [62:32] concurrent_stream_limit,
  // [93:63] initial_window_bytes, [117:94] frame_size_limit,
  // [148:118] header_list_limit, [151:149] zero
  output      logic [hsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] status
  output      logic [hsp_pkg::OUT_USER_W-1:0]    m_axis_tuser_o
);

  // Input register.
  logic            in_valid_q, in_valid_d;
  hsp_pkg::op_e    op_q;
  logic [7:0]      byte_q;
  logic            in_take;
  logic            proc;

  // Output register.
  logic             out_valid_q, out_valid_d;
  hsp_pkg::result_t res_q;
  hsp_pkg::result_t res;

  hsp_pkg::cmd_t   cmd;
  hsp_pkg::entry_t entry;

  // Only an end of payload needs the result register free.
  assign proc = in_valid_q &&
                ((op_q != hsp_pkg::OP_END) || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_take ? 1'b1 : (proc ? 1'b0 : in_valid_q);

  always_comb begin
    cmd = '0;
    if (proc) begin
      unique case (op_q)
        hsp_pkg::OP_BYTE:  cmd.byte_en  = 1'b1;
        hsp_pkg::OP_END:   cmd.end_en   = 1'b1;
        hsp_pkg::OP_CLEAR: cmd.clear_en = 1'b1;
        hsp_pkg::OP_NONE:  cmd          = '0;
        default:           cmd          = '0;
      endcase
    end
  end

  hsp_entry_asm u_entry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (byte_q),
    .entry_o     (entry)
  );

  hsp_view u_view (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .entry_i  (entry),
    .result_o (res)
  );

  assign out_valid_d = cmd.end_en ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= hsp_pkg::op_e'(s_axis_tuser_i);
      byte_q <= s_axis_tdata_i;
    end
    if (cmd.end_en) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {3'b000,
                            res_q.header_list_limit,
                            res_q.frame_size_limit,
                            res_q.initial_window_bytes,
                            res_q.concurrent_stream_limit,
                            res_q.header_table_bytes,
                            res_q.push_enabled};

  // Assertions.
  `HSP_ASSERT_NEXT(a_end_gives_result, cmd.end_en, m_axis_tvalid_o,
                   "end of payload lost its result")
  `HSP_ASSERT_SAME(a_stall_only_when_full, !s_axis_tready_o,
                   in_valid_q && (op_q == hsp_pkg::OP_END) && out_valid_q,
                   "input stalled without a pending result")
  `HSP_ASSERT_NEXT(a_clear_drops_entry, cmd.clear_en || cmd.end_en, !entry.partial,
                   "partial entry survived clear or end")
  `HSP_ASSERT_SAME(a_frame_floor, m_axis_tvalid_o,
                   res_q.frame_size_limit >= hsp_pkg::DEF_FRAME_SIZE,
                   "frame size below protocol minimum")

endmodule

`default_nettype wire
